/* hw/rtl/mst_pkg.sv */
`default_nettype none

package mst_pkg;

    // Field widths.
    localparam int KNOT_W  = 24;
    localparam int CNT_W   = 6;
    localparam int SLOPE_W = 32;
    localparam int IDX_W   = 5;

    // Largest curve that the block accepts.
    localparam int MAX_KNOTS = 32;

    // Internal arithmetic widths.
    // A knot difference spans 25 bits; times at most 31 it stays below 2^29.
    localparam int DIFF_W = KNOT_W + 1;
    localparam int SEC_W  = 31;
    localparam int MAG_W  = SEC_W - 1;
    localparam int SUM_W  = MAG_W + 1;
    localparam int PROD_W = 2 * MAG_W;
    localparam int NUM_W  = PROD_W + 2;
    localparam int QUO_W  = 32;

endpackage

`default_nettype wire

/* hw/rtl/mst_sermul.sv */
`default_nettype none

// Bit-serial shift-add multiplier: one multiplier bit per cycle.
module mst_sermul (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [mst_pkg::MAG_W-1:0]     op_a,
    input  wire logic [mst_pkg::MAG_W-1:0]     op_b,
    output logic                               done,
    output logic      [mst_pkg::PROD_W-1:0]    prod
);

    localparam int W     = mst_pkg::MAG_W;
    localparam int CNT_B = $clog2(W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_B-1:0] cnt_reg;
    logic [W-1:0]     acc_reg;
    logic [W-1:0]     mpl_reg;
    logic [W-1:0]     mcand_reg;
    logic [W:0]       sum_next;

    // Partial sum of the upper half with the multiplicand when the low bit is set.
    assign sum_next = {1'b0, acc_reg} + (mpl_reg[0] ? {1'b0, mcand_reg} : {(W+1){1'b0}});

    // Control counter and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_B'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Product shift register: the product shifts right one bit a cycle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg   <= '0;
            mpl_reg   <= op_a;
            mcand_reg <= op_b;
        end
        else if (busy_reg)
        begin
            acc_reg <= sum_next[W:1];
            mpl_reg <= {sum_next[0], mpl_reg[W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = {acc_reg, mpl_reg};

endmodule

`default_nettype wire

/* hw/rtl/mst_serdiv.sv */
`default_nettype none

// Restoring divider: one quotient bit per cycle. The caller guarantees that
// the quotient fits in QUO_W bits, so the upper numerator bits start as remainder.
module mst_serdiv (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [mst_pkg::NUM_W-1:0]     numer,
    input  wire logic [mst_pkg::SUM_W-1:0]     denom,
    output logic                               done,
    output logic      [mst_pkg::QUO_W-1:0]     quot
);

    localparam int QW    = mst_pkg::QUO_W;
    localparam int DW    = mst_pkg::SUM_W;
    localparam int HW    = mst_pkg::NUM_W - QW;
    localparam int CNT_B = $clog2(QW);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_B-1:0] cnt_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    den_reg;
    logic [QW-1:0]    sh_reg;
    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             fits;

    // One trial subtraction per cycle.
    assign trial = {rem_reg, sh_reg[QW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    // Control counter and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_B'(QW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and the shared numerator/quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {{(DW-HW){1'b0}}, numer[mst_pkg::NUM_W-1:QW]};
            sh_reg  <= numer[QW-1:0];
            den_reg <= denom;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DW-1:0] : trial[DW-1:0];
            sh_reg  <= {sh_reg[QW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = sh_reg;

endmodule

`default_nettype wire

/* hw/rtl/monotone_spline_tangents_unit.sv */
// An end-knot tangent reaches the output register through ST_SEC, ST_PREP and ST_EMIT1,
// or ST_EMIT2 for the knot that closes the curve; a harmonic-mean tangent also passes
// through the bit-serial multiplier and the bit-serial divider of the harmonic mean.
// One knot at a time: a new knot is taken only back in ST_IDLE, a bad count goes
// straight to ST_EMIT1, and a curve's first knot is only stored.
// Reset (rst_n, asynchronous, active low): knot count 32, curve restarts at knot 0.
`default_nettype none

module monotone_spline_tangents_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Configuration write channel.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic        [mst_pkg::CNT_W-1:0]  knot_count,
    // Knot input channel.
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [mst_pkg::KNOT_W-1:0] tone_value,
    // Tangent output channel.
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [mst_pkg::SLOPE_W-1:0]     slope_value,
    output logic        [mst_pkg::IDX_W-1:0]       knot_index,
    output logic                                   count_bad,
    output logic                                   last
);

    localparam int KW = mst_pkg::KNOT_W;
    localparam int CW = mst_pkg::CNT_W;
    localparam int SW = mst_pkg::SEC_W;
    localparam int MW = mst_pkg::MAG_W;
    localparam int OW = mst_pkg::SLOPE_W;
    localparam int IW = mst_pkg::IDX_W;
    localparam int QW = mst_pkg::QUO_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEC,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_EMIT1,
        ST_EMIT2
    } state_t;

    state_t                 state_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          pos_reg;
    logic signed [KW-1:0]   prev_knot_reg;
    logic signed [KW-1:0]   x_reg;
    logic signed [SW-1:0]   prev_sec_reg;
    logic signed [SW-1:0]   sec_reg;
    logic [mst_pkg::SUM_W-1:0] sum_reg;
    logic                   neg_reg;
    logic                   two_reg;

    // Pending results.
    logic [OW-1:0]          r1_slope_reg;
    logic [IW-1:0]          r1_idx_reg;
    logic                   r1_bad_reg;
    logic                   r1_last_reg;
    logic [OW-1:0]          r2_slope_reg;
    logic [IW-1:0]          r2_idx_reg;

    // Output register.
    logic                   out_valid_reg;
    logic [OW-1:0]          slope_reg;
    logic [IW-1:0]          idx_reg;
    logic                   bad_reg;
    logic                   last_reg;

    // Serial unit connections.
    logic                       mul_start;
    logic                       mul_done;
    logic [mst_pkg::PROD_W-1:0] prod;
    logic                       div_start;
    logic                       div_done;
    logic [QW-1:0]              quot;
    logic [mst_pkg::NUM_W-1:0]  numer;

    logic                   in_acc;
    logic                   out_free;
    logic                   out_load;
    logic                   bad_count;
    logic [CW-1:0]          cnt_m1;
    logic signed [mst_pkg::DIFF_W-1:0]      diff;
    logic signed [mst_pkg::DIFF_W+CW:0]     sec_full;
    logic signed [SW-1:0]   sec_next;
    logic                   final_knot;
    logic                   no_mean;
    logic [SW-1:0]          abs_a;
    logic [SW-1:0]          abs_b;
    logic [MW-1:0]          mag_a;
    logic [MW-1:0]          mag_b;
    logic [mst_pkg::SUM_W-1:0] sum_next;
    logic [OW-1:0]          sec_slope;
    logic [QW-1:0]          q_clamp;
    logic [OW-1:0]          mean_slope;

    // Register writes are taken between knots; a pending write holds off the next knot.
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = out_free && ((state_reg == ST_EMIT1) || (state_reg == ST_EMIT2));

    // Count check.
    assign bad_count = (count_reg < CW'(2)) || (count_reg > CW'(mst_pkg::MAX_KNOTS));
    assign cnt_m1    = count_reg - 1'b1;

    // Secant: knot difference times (count - 1), exact in SEC_W bits.
    assign diff     = {x_reg[KW-1], x_reg} - {prev_knot_reg[KW-1], prev_knot_reg};
    assign sec_full = diff * $signed({1'b0, cnt_m1});
    assign sec_next = sec_full[SW-1:0];

    // Tangent selection for the knot before the current one.
    assign final_knot = (pos_reg >= cnt_m1);
    assign no_mean    = (prev_sec_reg == '0) || (sec_reg == '0)
                        || (prev_sec_reg[SW-1] != sec_reg[SW-1]);
    assign abs_a      = prev_sec_reg[SW-1] ? (-prev_sec_reg) : prev_sec_reg;
    assign abs_b      = sec_reg[SW-1] ? (-sec_reg) : sec_reg;
    assign mag_a      = abs_a[MW-1:0];
    assign mag_b      = abs_b[MW-1:0];
    assign sum_next   = {1'b0, mag_a} + {1'b0, mag_b};
    assign sec_slope  = {{(OW-SW){sec_reg[SW-1]}}, sec_reg};

    // Harmonic mean: round(2ab / (a+b)) with half the divisor added before dividing.
    assign mul_start = (state_reg == ST_PREP) && (pos_reg != CW'(1)) && !no_mean;
    assign div_start = (state_reg == ST_MUL) && mul_done;
    assign numer     = {1'b0, prod, 1'b0}
                       + {{(mst_pkg::NUM_W-mst_pkg::SUM_W+1){1'b0}},
                          sum_reg[mst_pkg::SUM_W-1:1]};

    // Clamp the magnitude to 2^31, then apply the sign and saturate.
    assign q_clamp    = (quot > {1'b1, {(QW-1){1'b0}}}) ? {1'b1, {(QW-1){1'b0}}} : quot;
    assign mean_slope = neg_reg ? (-q_clamp)
                        : (q_clamp[QW-1] ? {1'b0, {(OW-1){1'b1}}} : q_clamp);

    mst_sermul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .op_a  (mag_a),
        .op_b  (mag_b),
        .done  (mul_done),
        .prod  (prod)
    );

    mst_serdiv u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (numer),
        .denom (sum_reg),
        .done  (div_done),
        .quot  (quot)
    );

    // Sequencer, curve state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= CW'(mst_pkg::MAX_KNOTS);
            pos_reg       <= '0;
            prev_knot_reg <= '0;
            prev_sec_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // The output register fills from a pending result and empties when its
            // transaction completes.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    // A configuration write restarts the curve.
                    if (cfg_valid && cfg_ready)
                    begin
                        count_reg <= knot_count;
                        pos_reg   <= '0;
                    end
                    else if (in_acc)
                    begin
                        x_reg <= tone_value;
                        if (bad_count)
                        begin
                            r1_slope_reg <= '0;
                            r1_idx_reg   <= '0;
                            r1_bad_reg   <= 1'b1;
                            r1_last_reg  <= 1'b1;
                            two_reg      <= 1'b0;
                            pos_reg      <= '0;
                            state_reg    <= ST_EMIT1;
                        end
                        else if (pos_reg == '0)
                        begin
                            prev_knot_reg <= tone_value;
                            pos_reg       <= CW'(1);
                        end
                        else
                        begin
                            state_reg <= ST_SEC;
                        end
                    end
                end

                ST_SEC:
                begin
                    sec_reg   <= sec_next;
                    state_reg <= ST_PREP;
                end

                ST_PREP:
                begin
                    r1_bad_reg    <= 1'b0;
                    r1_last_reg   <= 1'b0;
                    r2_slope_reg  <= sec_slope;
                    r2_idx_reg    <= pos_reg[IW-1:0];
                    two_reg       <= final_knot;
                    sum_reg       <= sum_next;
                    neg_reg       <= sec_reg[SW-1];
                    prev_knot_reg <= x_reg;
                    prev_sec_reg  <= sec_reg;
                    pos_reg       <= final_knot ? '0 : (pos_reg + 1'b1);
                    if (pos_reg == CW'(1))
                    begin
                        r1_slope_reg <= sec_slope;
                        r1_idx_reg   <= '0;
                        state_reg    <= ST_EMIT1;
                    end
                    else
                    begin
                        r1_idx_reg <= pos_reg[IW-1:0] - 1'b1;
                        if (no_mean)
                        begin
                            r1_slope_reg <= '0;
                            state_reg    <= ST_EMIT1;
                        end
                        else
                        begin
                            state_reg <= ST_MUL;
                        end
                    end
                end

                ST_MUL:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    if (div_done)
                    begin
                        r1_slope_reg <= mean_slope;
                        state_reg    <= ST_EMIT1;
                    end
                end

                ST_EMIT1:
                begin
                    if (out_free)
                    begin
                        slope_reg     <= r1_slope_reg;
                        idx_reg       <= r1_idx_reg;
                        bad_reg       <= r1_bad_reg;
                        last_reg      <= r1_last_reg;
                        state_reg     <= two_reg ? ST_EMIT2 : ST_IDLE;
                    end
                end

                ST_EMIT2:
                begin
                    if (out_free)
                    begin
                        slope_reg     <= r2_slope_reg;
                        idx_reg       <= r2_idx_reg;
                        bad_reg       <= 1'b0;
                        last_reg      <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign slope_value = slope_reg;
    assign knot_index  = idx_reg;
    assign count_bad   = bad_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

/* hw/rtl/mst_checker.sv */
`default_nettype none

module mst_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic signed [mst_pkg::SLOPE_W-1:0] slope_value,
    input wire logic        [mst_pkg::IDX_W-1:0]  knot_index,
    input wire logic                              count_bad,
    input wire logic                              last
);

    // A stalled tangent transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(slope_value)
            && $stable(knot_index) && $stable(count_bad) && $stable(last))
    else $error("output payload changed while stalled");

    // A knot offered but not yet taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
    else $error("input valid dropped while stalled");

    // A bad count gives a zero slope on knot 0 that closes the curve.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && count_bad |-> slope_value == '0 && knot_index == '0 && last)
    else $error("bad-count result malformed");

    // The final tangent of a good curve never belongs to knot 0.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last && !count_bad |-> knot_index != '0)
    else $error("final tangent on knot 0");

endmodule

bind monotone_spline_tangents_unit mst_checker u_mst_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .slope_value (slope_value),
    .knot_index  (knot_index),
    .count_bad   (count_bad),
    .last        (last)
);

`default_nettype wire
